// ----- sv/fxc_pkg.sv -----
`default_nettype none
package fxc_pkg;

   localparam int MAX_MSG_BYTES = 100;
   localparam int FLAG_RUN      = 5;

   localparam int HDR_BYTES = 5;
   localparam int FTR_BYTES = 5;
   localparam int MIN_FRAME = HDR_BYTES + FTR_BYTES;

   localparam logic [7:0] FLAG_BYTE = 8'hFF;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 7;
   localparam int POS_W  = $clog2(MAX_MSG_BYTES);
   localparam int RUN_W  = $clog2(FLAG_RUN + 1);
   localparam int SUM_W  = 32;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic {
      REQ_BYTE  = 1'b0,
      REQ_TABLE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_CSUM = 2'd1,
      STATUS_LEN  = 2'd2
   } status_type;

   typedef enum logic {
      PH_HUNT  = 1'b0,
      PH_FRAME = 1'b1
   } phase_type;

   typedef struct packed {
      logic              rd_en;
      logic [BYTE_W-1:0] rd_addr;
      logic              wr_en;
      logic [BYTE_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } tbl_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [BYTE_W-1:0] out_msg_id;
      logic [IDX_W-1:0]  out_index;
      logic              out_last;
      status_type        out_status;
   } rsp_item_type;

endpackage
`default_nettype wire

// ----- sv/fxc_size_table.sv -----
`default_nettype none
module fxc_size_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fxc_pkg::tbl_req_type          tbl_req,
   output logic      [fxc_pkg::BYTE_W-1:0]    frame_size
);
   import fxc_pkg::*;

   localparam int DEPTH = 2 ** BYTE_W;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic              rd_vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (tbl_req.wr_en) begin
         vld_in[tbl_req.wr_addr] = 1'b1;
      end
      rd_vld_in = tbl_req.rd_en ? vld_ff[tbl_req.rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // never-written entries read as zero size
   assign frame_size = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ----- sv/fxc_deframer.sv -----
`default_nettype none
module fxc_deframer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire fxc_pkg::req_kind_type         in_kind,
   input  wire logic [fxc_pkg::BYTE_W-1:0]    in_byte,
   input  wire logic [fxc_pkg::BYTE_W-1:0]    in_tbl_id,
   input  wire logic [fxc_pkg::BYTE_W-1:0]    in_tbl_size,
   output fxc_pkg::tbl_req_type               tbl_req,
   input  wire logic [fxc_pkg::BYTE_W-1:0]    frame_size,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output fxc_pkg::rsp_item_type              out_item
);
   import fxc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [SUM_W-1:0]  xor_ff, xor_in;
   logic [SUM_W-1:0]  ftr_ff, ftr_in;
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      item_ff;
   rsp_item_type      item_in;

   logic              accept;
   logic              serial;
   logic              first;
   logic              produce;
   logic              last;
   logic              bad_len;
   logic [RUN_W-1:0]  run_inc;
   logic [BYTE_W-1:0] p8;
   logic [BYTE_W-1:0] data_end;
   logic [BYTE_W-1:0] ftr_k;
   logic [SUM_W-1:0]  xor_base;
   logic [SUM_W-1:0]  ftr_base;
   status_type        status;

   assign in_ready = !out_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign serial   = (in_kind == REQ_BYTE);
   assign first    = (pos_ff == '0);
   assign produce  = accept && serial && (phase_ff == PH_FRAME);
   assign run_inc  = run_ff + RUN_W'(1);

   assign tbl_req.rd_en   = produce && first;
   assign tbl_req.rd_addr = in_byte;
   assign tbl_req.wr_en   = accept && !serial;
   assign tbl_req.wr_addr = in_tbl_id;
   assign tbl_req.wr_data = in_tbl_size;

   // frame_size is stale on header byte 0; nothing there depends on it
   always_comb begin
      p8       = BYTE_W'(pos_ff);
      data_end = (frame_size >= BYTE_W'(MIN_FRAME)) ? frame_size - BYTE_W'(FTR_BYTES)
                                                    : BYTE_W'(HDR_BYTES);
      ftr_k    = p8 - data_end;
      bad_len  = (frame_size < BYTE_W'(MIN_FRAME)) || (frame_size > BYTE_W'(MAX_MSG_BYTES));
      xor_base = first ? '0 : xor_ff;
      ftr_base = first ? '0 : ftr_ff;
      xor_in   = xor_ff;
      ftr_in   = ftr_ff;
      id_in    = id_ff;
      last     = 1'b0;
      status   = STATUS_OK;
      if (produce) begin
         id_in  = first ? in_byte : id_ff;
         xor_in = xor_base;
         ftr_in = ftr_base;
         if (p8 < data_end) begin
            xor_in = xor_base ^ (SUM_W'(in_byte) << {pos_ff[1:0], 3'b000});
         end
         if (p8 == BYTE_W'(HDR_BYTES - 1) && bad_len) begin
            last   = 1'b1;
            status = STATUS_LEN;
         end else if (p8 >= data_end) begin
            if (ftr_k < BYTE_W'(4)) begin
               ftr_in = ftr_base | (SUM_W'(in_byte) << {ftr_k[1:0], 3'b000});
            end else begin
               last   = 1'b1;
               status = (xor_ff == ftr_ff) ? STATUS_OK : STATUS_CSUM;
            end
         end
      end
      item_in.out_byte   = in_byte;
      item_in.out_msg_id = id_in;
      item_in.out_index  = IDX_W'(pos_ff);
      item_in.out_last   = last;
      item_in.out_status = status;
      out_valid_in = produce ? 1'b1 : (out_valid_ff && !out_ready);
   end

   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      pos_in   = pos_ff;
      if (accept && serial) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (in_byte == FLAG_BYTE) begin
                  if (run_inc >= RUN_W'(FLAG_RUN)) begin
                     phase_in = PH_FRAME;
                     run_in   = '0;
                     pos_in   = '0;
                  end else begin
                     run_in = run_inc;
                  end
               end else begin
                  run_in = '0;
               end
            end
            PH_FRAME: begin
               if (last) begin
                  phase_in = PH_HUNT;
                  run_in   = '0;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         run_ff       <= '0;
         pos_ff       <= '0;
         id_ff        <= '0;
         xor_ff       <= '0;
         ftr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         pos_ff       <= pos_in;
         id_ff        <= id_in;
         xor_ff       <= xor_in;
         ftr_ff       <= ftr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = item_ff;

`ifndef SYNTHESIS
   a_hunt_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (pos_ff == '0))
      else $error("byte position not cleared while hunting");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (produce && last) |=> (phase_ff == PH_HUNT && run_ff == '0))
      else $error("frame did not end after last item");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FRAME) |-> (BYTE_W'(pos_ff) < BYTE_W'(MAX_MSG_BYTES)))
      else $error("byte position beyond maximum frame size");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff < RUN_W'(FLAG_RUN))
      else $error("flag run counter out of range");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      produce |=> (out_valid_ff && item_ff.out_index == IDX_W'($past(pos_ff))))
      else $error("result register not loaded for frame item");
`endif

endmodule
`default_nettype wire

// ----- sv/flagged_frame_xor_checker.sv -----
`default_nettype none
// Serial deframer: hunts for a run of FLAG_RUN 0xFF bytes, then passes every frame byte
// (5-byte header, payload, 5-byte footer) out tagged with message id, index and, on the
// final byte, a status (ok, checksum mismatch, bad length). Frame size comes from a
// 256-entry size table loaded with table-write items; reset clears it through per-entry
// valid bits, so there is no clearing pass. One item is accepted every cycle while the
// output register is empty or being drained; each result is held in the single result
// register behind per-byte XOR/counter logic, shown the cycle after its item is accepted.
module flagged_frame_xor_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [7:0] rx_byte, [15:8] table_id, [23:16] table_size
   input  wire logic [fxc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] req_type
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] out_byte, [15:8] out_msg_id, [22:16] out_index, [24:23] out_status, rest zero
   output logic      [fxc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                   rsp_tlast
);
   import fxc_pkg::*;

   tbl_req_type       tbl_req;
   logic [BYTE_W-1:0] frame_size;
   rsp_item_type      item;
   req_kind_type      kind;

   assign kind = req_kind_type'(req_tuser);

   fxc_size_table u_size_table (
      .clock      (clock),
      .reset      (reset),
      .tbl_req    (tbl_req),
      .frame_size (frame_size)
   );

   fxc_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (kind),
      .in_byte     (req_tdata[7:0]),
      .in_tbl_id   (req_tdata[15:8]),
      .in_tbl_size (req_tdata[23:16]),
      .tbl_req     (tbl_req),
      .frame_size  (frame_size),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_item    (item)
   );

   assign rsp_tdata = {7'b0, item.out_status, item.out_index, item.out_msg_id, item.out_byte};
   assign rsp_tlast = item.out_last;

endmodule
`default_nettype wire
